// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the text console writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/tcw_pkg.sv =====
// Package with the types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int NUM_COLUMNS = 80;
  localparam int NUM_ROWS    = 24;
  localparam int CELL_COUNT  = NUM_COLUMNS * NUM_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  // Field widths.
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);

  // Item kinds.
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Character codes that start a new line.
  localparam logic [BYTE_W-1:0] LINE_FEED       = 8'd10;
  localparam logic [BYTE_W-1:0] CARRIAGE_RETURN = 8'd13;

  // Attribute register reset value.
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [BYTE_W-1:0] cell_char;
    logic [BYTE_W-1:0] cell_attr;
    logic              scrolled;
  } out_item_t;

  // Request from the sequencer to the address unit (logical row and column).
  typedef struct packed {
    logic              we;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] data;
  } au_req_t;

  // Command from the address unit to the screen store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/tcw_store.sv =====
// Screen store: one cell per entry, character in the upper byte, attribute in the lower.
`default_nettype none

module tcw_store (
  input  wire                         clk,
  input  tcw_pkg::mem_cmd_t           cmd,
  output logic [tcw_pkg::CELL_W-1:0]  rdata_r
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  // One write and one registered read per cycle at the same address.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= cmd.data;
    end
    rdata_r <= mem[cmd.addr];
  end

endmodule

`default_nettype wire

// ===== hdl/tcw_addr.sv =====
// Shared two-stage address unit: rotates the logical row by the scroll base and
// forms the linear cell address.
`default_nettype none

module tcw_addr (
  input  wire                        clk,
  input  wire                        rst_n,
  input  tcw_pkg::au_req_t           req,
  input  wire [tcw_pkg::ROW_W-1:0]   base,
  output tcw_pkg::mem_cmd_t          cmd
);
  import tcw_pkg::*;

  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  prow_nxt;
  logic [ROW_W-1:0]  prow_r;
  logic [COL_W-1:0]  col_r;
  logic [CELL_W-1:0] data1_r;
  logic              we1_r;
  logic [ADDR_W-1:0] addr_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [CELL_W-1:0] data2_r;
  logic              we2_r;

  // Stage one: physical row is the logical row plus the base, modulo the row count.
  always_comb begin
    row_sum = {1'b0, req.row} + {1'b0, base};
    if (row_sum >= (ROW_W + 1)'(NUM_ROWS)) begin
      prow_nxt = ROW_W'(row_sum - (ROW_W + 1)'(NUM_ROWS));
    end else begin
      prow_nxt = row_sum[ROW_W-1:0];
    end
  end

  // Stage two: row times the row length plus the column.
  assign addr_nxt = ADDR_W'(prow_r) * ADDR_W'(NUM_COLUMNS) + ADDR_W'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      we1_r <= 1'b0;
      we2_r <= 1'b0;
    end else begin
      we1_r <= req.we;
      we2_r <= we1_r;
    end
  end

  always_ff @(posedge clk) begin
    prow_r  <= prow_nxt;
    col_r   <= req.col;
    data1_r <= req.data;
    addr_r  <= addr_nxt;
    data2_r <= data1_r;
  end

  assign cmd.we   = we2_r;
  assign cmd.addr = addr_r;
  assign cmd.data = data2_r;

endmodule

`default_nettype wire

// ===== hdl/tcw_seq.sv =====
// Sequencer: cursor, scroll base, attribute register and the store sweeps.
`default_nettype none

module tcw_seq (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  tcw_pkg::in_item_t           in_item,
  input  wire                         cfg_we,
  input  wire [tcw_pkg::BYTE_W-1:0]   cfg_wdata,
  input  wire [tcw_pkg::CELL_W-1:0]   rdata,
  output logic                        busy,
  output tcw_pkg::au_req_t            req,
  output logic [tcw_pkg::ROW_W-1:0]   base_r,
  output logic                        out_valid_r,
  output tcw_pkg::out_item_t          out_r
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BLANK = 3'd2;
  localparam logic [2:0] S_CLR   = 3'd3;
  localparam logic [2:0] S_RDW   = 3'd4;

  localparam logic [1:0] RD_LAST = 2'd2;

  logic [2:0]        state_r,     state_nxt;
  logic [ROW_W-1:0]  row_cnt_r,   row_cnt_nxt;
  logic [COL_W-1:0]  col_cnt_r,   col_cnt_nxt;
  logic [1:0]        wait_r,      wait_nxt;
  logic [ROW_W-1:0]  base_nxt;
  logic [ROW_W-1:0]  cur_row_r,   cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r,   cur_col_nxt;
  logic [BYTE_W-1:0] attr_r,      attr_nxt;
  logic              out_valid_nxt;
  out_item_t         out_nxt;
  logic              new_line;

  assign busy = (state_r != S_IDLE);

  assign attr_nxt = cfg_we ? cfg_wdata : attr_r;

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    wait_nxt      = wait_r;
    base_nxt      = base_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    req           = '0;
    new_line      = (in_item.char_code == LINE_FEED) ||
                    (in_item.char_code == CARRIAGE_RETURN);

    case (state_r)
      // Zero every cell, row by row; a clear item also reports at the end.
      S_INIT, S_CLR: begin
        req.we  = 1'b1;
        req.row = row_cnt_r;
        req.col = col_cnt_r;
        if (col_cnt_r == LAST_COL) begin
          col_cnt_nxt = '0;
          if (row_cnt_r == LAST_ROW) begin
            row_cnt_nxt = '0;
            state_nxt   = S_IDLE;
            if (state_r == S_CLR) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
            end
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end

      // Blank the new bottom row after a scroll.
      S_BLANK: begin
        req.we  = 1'b1;
        req.row = LAST_ROW;
        req.col = col_cnt_r;
        if (col_cnt_r == LAST_COL) begin
          col_cnt_nxt   = '0;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = '{cur_row_r, cur_col_r, '0, '0, 1'b1};
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
        end
      end

      // Wait for the read beat to come back from the store.
      S_RDW: begin
        wait_nxt = wait_r + 1'b1;
        if (wait_r == RD_LAST) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = '{cur_row_r, cur_col_r, rdata[CELL_W-1:BYTE_W],
                            rdata[BYTE_W-1:0], 1'b0};
        end
      end

      S_IDLE: begin
        if (start) begin
          case (in_item.kind)
            KIND_PUT: begin
              if (!new_line) begin
                req.we   = 1'b1;
                req.row  = cur_row_r;
                req.col  = cur_col_r;
                req.data = {in_item.char_code, attr_r};
              end
              if (new_line || (cur_col_r == LAST_COL)) begin
                cur_col_nxt = '0;
                if (cur_row_r == LAST_ROW) begin
                  // Scroll by moving the base; the old top row becomes the bottom.
                  base_nxt    = (base_r == LAST_ROW) ? '0 : base_r + 1'b1;
                  col_cnt_nxt = '0;
                  state_nxt   = S_BLANK;
                end else begin
                  cur_row_nxt   = cur_row_r + 1'b1;
                  out_valid_nxt = 1'b1;
                  out_nxt       = '{cur_row_r + 1'b1, '0, '0, '0, 1'b0};
                end
              end else begin
                cur_col_nxt   = cur_col_r + 1'b1;
                out_valid_nxt = 1'b1;
                out_nxt       = '{cur_row_r, cur_col_r + 1'b1, '0, '0, 1'b0};
              end
            end
            KIND_CLEAR: begin
              base_nxt    = '0;
              row_cnt_nxt = '0;
              col_cnt_nxt = '0;
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              state_nxt   = S_CLR;
            end
            KIND_READ: begin
              if ((in_item.read_row <= LAST_ROW) && (in_item.read_col <= LAST_COL)) begin
                req.row   = in_item.read_row;
                req.col   = in_item.read_col;
                wait_nxt  = '0;
                state_nxt = S_RDW;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = '{cur_row_r, cur_col_r, '0, '0, 1'b0};
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{cur_row_r, cur_col_r, '0, '0, 1'b0};
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      wait_r      <= '0;
      base_r      <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      wait_r      <= wait_nxt;
      base_r      <= base_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/text_console_writer_core.sv =====
// Top level of the text console writer: sequencer, address unit and screen store.
//
// Use: drive in_item and raise start; the item is taken at a clock edge where
// start is high and busy is low. Exactly one result beat follows per item on
// out_item, marked by out_valid for a single cycle; the receiver cannot stall,
// so it must take the beat in that cycle. The attribute register is written by
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce (reset value 7). A printed character, a new
// line without scroll, an unused kind or an out-of-range read is reported in the
// cycle after the accepting edge; a read in range first passes the two address
// stages and the registered store read, a scroll first blanks the bottom row and
// a clear first writes every cell.
// Scrolling moves a row base register instead of copying the store, so only
// one row is rewritten. The sweeps share the single address unit, one cell per
// cycle, and busy stays high until the cycle in which the result beat is issued.
// After reset the block runs a clearing pass over all 1920 cells, with busy
// high; configuration writes are taken during that pass.
`default_nettype none
`include "assert_macros.svh"

module text_console_writer_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  tcw_pkg::in_item_t            in_item,
  output logic                         out_valid,
  output tcw_pkg::out_item_t           out_item,
  input  wire                          cfg_we,
  input  wire [tcw_pkg::BYTE_W-1:0]    cfg_wdata
);
  import tcw_pkg::*;

  au_req_t           req;
  mem_cmd_t          cmd;
  logic [ROW_W-1:0]  base;
  logic [CELL_W-1:0] rdata;

  // Sequencer with cursor and attribute state.
  tcw_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_item     (in_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .rdata       (rdata),
    .busy        (busy),
    .req         (req),
    .base_r      (base),
    .out_valid_r (out_valid),
    .out_r       (out_item)
  );

  // Shared address unit.
  tcw_addr u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .base  (base),
    .cmd   (cmd)
  );

  // Character and attribute store.
  tcw_store u_store (
    .clk     (clk),
    .cmd     (cmd),
    .rdata_r (rdata)
  );

  `TCW_ASSERT_IMP(a_cursor_range, clk, rst_n, out_valid, (out_item.cursor_row <= LAST_ROW) && (out_item.cursor_col <= LAST_COL))
  `TCW_ASSERT_IMP(a_scroll_pos, clk, rst_n, out_valid && out_item.scrolled, (out_item.cursor_row == LAST_ROW) && (out_item.cursor_col == '0))
  `TCW_ASSERT_IMP(a_addr_range, clk, rst_n, cmd.we, cmd.addr < ADDR_W'(CELL_COUNT))
  `TCW_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the text console writer core.
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  // The one kind code that the package leaves unnamed: it changes nothing.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int  PHASE_BEATS = 460;
  localparam int  MAX_GAP     = 30;
  // Worst case: every beat a full clear plus the longest sender gap, taken
  // several times over.
  localparam longint CYCLE_LIMIT = 64'd4 * (3 * PHASE_BEATS + 100) * (CELL_COUNT + 40);
  localparam int  PRINT_CAP   = 100;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } probe_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  // Shadow copy of the screen, the cursor and the attribute register.
  logic [BYTE_W-1:0] shadow_char [NUM_ROWS][NUM_COLUMNS];
  logic [BYTE_W-1:0] shadow_attr [NUM_ROWS][NUM_COLUMNS];
  int unsigned       crsr_row;
  int unsigned       crsr_col;
  logic [BYTE_W-1:0] attr_now;

  out_item_t  screen_expect_q [$];
  probe_row_t directed_rows [$];
  int         mismatch_count;
  longint     cycle_count;

  text_console_writer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // One line per mismatch; printing stops after a cap but counting goes on.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  // Zeroes every cell of the shadow screen and homes the cursor.
  function automatic void blank_screen();
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        shadow_char[r][c] = '0;
        shadow_attr[r][c] = '0;
      end
    end
    crsr_row = 0;
    crsr_col = 0;
  endfunction

  // Starts a new line, scrolling when already on the bottom row.
  function automatic bit shift_to_next_line();
    bit did;
    did = 1'b0;
    if (crsr_row + 1 >= NUM_ROWS) begin
      for (int r = 0; r < NUM_ROWS - 1; r++) begin
        for (int c = 0; c < NUM_COLUMNS; c++) begin
          shadow_char[r][c] = shadow_char[r+1][c];
          shadow_attr[r][c] = shadow_attr[r+1][c];
        end
      end
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        shadow_char[NUM_ROWS-1][c] = '0;
        shadow_attr[NUM_ROWS-1][c] = '0;
      end
      crsr_row = NUM_ROWS - 1;
      did = 1'b1;
    end else begin
      crsr_row++;
    end
    crsr_col = 0;
    return did;
  endfunction

  // Applies one beat to the shadow screen and returns the result it causes.
  function automatic out_item_t apply_to_screen(input in_item_t it);
    out_item_t res;
    res = '0;
    case (it.kind)
      KIND_PUT: begin
        if (it.char_code == LINE_FEED || it.char_code == CARRIAGE_RETURN) begin
          res.scrolled = shift_to_next_line();
        end else begin
          shadow_char[crsr_row][crsr_col] = it.char_code;
          shadow_attr[crsr_row][crsr_col] = attr_now;
          crsr_col++;
          if (crsr_col >= NUM_COLUMNS) res.scrolled = shift_to_next_line();
        end
      end
      KIND_CLEAR: blank_screen();
      KIND_READ: begin
        if (it.read_row < NUM_ROWS && it.read_col < NUM_COLUMNS) begin
          res.cell_char = shadow_char[it.read_row][it.read_col];
          res.cell_attr = shadow_attr[it.read_row][it.read_col];
        end
      end
      default: ;
    endcase
    res.cursor_row = ROW_W'(crsr_row);
    res.cursor_col = COL_W'(crsr_col);
    return res;
  endfunction

  // Directed row whose result comes from the shadow model.
  function automatic probe_row_t model_row(input logic [1:0] k,
                                           input logic [BYTE_W-1:0] code,
                                           input logic [ROW_W-1:0] rr,
                                           input logic [COL_W-1:0] rc);
    probe_row_t row;
    row.item   = '{kind: k, char_code: code, read_row: rr, read_col: rc};
    row.typed  = 1'b0;
    row.result = '0;
    return row;
  endfunction

  // Directed row with its result written out by hand.
  function automatic probe_row_t typed_row(input logic [1:0] k,
                                           input logic [BYTE_W-1:0] code,
                                           input logic [ROW_W-1:0] rr,
                                           input logic [COL_W-1:0] rc,
                                           input logic [ROW_W-1:0] er,
                                           input logic [COL_W-1:0] ec,
                                           input logic [BYTE_W-1:0] ech,
                                           input logic [BYTE_W-1:0] eat,
                                           input logic es);
    probe_row_t row;
    row = model_row(k, code, rr, rc);
    row.typed  = 1'b1;
    row.result = '{cursor_row: er, cursor_col: ec, cell_char: ech,
                   cell_attr: eat, scrolled: es};
    return row;
  endfunction

  // Drives one beat after a random gap and records what it should produce.
  task automatic send_beat(input in_item_t it, input int idle_pct,
                           input bit typed, input out_item_t typed_res);
    int        gap;
    out_item_t res;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    res = apply_to_screen(it);
    screen_expect_q.push_back(typed ? typed_res : res);
  endtask

  // Drops start and waits for every outstanding result beat.
  task automatic await_drain();
    @(negedge clk);
    start <= 1'b0;
    while (screen_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the attribute register; called while the block is idle, and once during the post-reset clearing pass.
  task automatic write_attr(input logic [BYTE_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    attr_now = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random item with every field random; callers override what they need.
  function automatic in_item_t noise_item();
    in_item_t it;
    it.kind      = 2'($urandom_range(3));
    it.char_code = BYTE_W'($urandom_range(255));
    it.read_row  = ROW_W'($urandom_range(31));
    it.read_col  = COL_W'($urandom_range(127));
    return it;
  endfunction

  // Random traffic built from runs of text, new lines, reads and noise.
  task automatic run_phase(input int beats, input int idle_pct);
    int       sent;
    int       run_len;
    int       sel;
    bit       drained;
    in_item_t it;
    sent    = 0;
    drained = 1'b0;
    while (sent < beats) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        // A line of text, long enough at times to wrap, maybe ended by a new line.
        run_len = ($urandom_range(9) == 0) ? $urandom_range(75, 95) : $urandom_range(1, 40);
        for (int i = 0; i < run_len; i++) begin
          it = noise_item();
          it.kind = KIND_PUT;
          send_beat(it, idle_pct, 1'b0, '0);
        end
        if ($urandom_range(1)) begin
          it = noise_item();
          it.kind      = KIND_PUT;
          it.char_code = $urandom_range(1) ? LINE_FEED : CARRIAGE_RETURN;
          send_beat(it, idle_pct, 1'b0, '0);
          run_len++;
        end
      end else if (sel < 55) begin
        // A burst of new lines that often reaches the bottom row and scrolls.
        run_len = $urandom_range(1, 30);
        for (int i = 0; i < run_len; i++) begin
          it = noise_item();
          it.kind      = KIND_PUT;
          it.char_code = $urandom_range(1) ? LINE_FEED : CARRIAGE_RETURN;
          send_beat(it, idle_pct, 1'b0, '0);
        end
      end else if (sel < 80) begin
        // Reads, mostly of cells on screen, some anywhere in the field range.
        run_len = $urandom_range(1, 12);
        for (int i = 0; i < run_len; i++) begin
          it = noise_item();
          it.kind = KIND_READ;
          if ($urandom_range(9) != 0) begin
            it.read_row = ROW_W'($urandom_range(NUM_ROWS - 1));
            it.read_col = COL_W'($urandom_range(NUM_COLUMNS - 1));
          end
          send_beat(it, idle_pct, 1'b0, '0);
        end
      end else if (sel < 83) begin
        it = noise_item();
        it.kind = KIND_CLEAR;
        send_beat(it, idle_pct, 1'b0, '0);
        run_len = 1;
      end else if (sel < 90) begin
        // Noise: any kind, any fields.
        run_len = $urandom_range(1, 6);
        for (int i = 0; i < run_len; i++) begin
          send_beat(noise_item(), idle_pct, 1'b0, '0);
        end
      end else begin
        // Characters close to the new-line codes.
        run_len = $urandom_range(1, 10);
        for (int i = 0; i < run_len; i++) begin
          it = noise_item();
          it.kind      = KIND_PUT;
          it.char_code = BYTE_W'($urandom_range(8, 15));
          send_beat(it, idle_pct, 1'b0, '0);
        end
      end
      sent += run_len;
      // Once per phase the sender holds off until every result is back.
      if (!drained && sent >= beats / 2) begin
        await_drain();
        drained = 1'b1;
      end
    end
    await_drain();
  endtask

  // Cycle limit and result checking, both on the rising edge.
  always @(posedge clk) begin : result_check
    out_item_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_n && out_valid) begin
      if (screen_expect_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = screen_expect_q.pop_front();
        if (out_item.cursor_row !== want.cursor_row)
          report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                    out_item.cursor_row, want.cursor_row));
        if (out_item.cursor_col !== want.cursor_col)
          report_mismatch($sformatf("cursor_col %0d, expected %0d",
                                    out_item.cursor_col, want.cursor_col));
        if (out_item.cell_char !== want.cell_char)
          report_mismatch($sformatf("cell_char %02h, expected %02h",
                                    out_item.cell_char, want.cell_char));
        if (out_item.cell_attr !== want.cell_attr)
          report_mismatch($sformatf("cell_attr %02h, expected %02h",
                                    out_item.cell_attr, want.cell_attr));
        if (out_item.scrolled !== want.scrolled)
          report_mismatch($sformatf("scrolled %0b, expected %0b",
                                    out_item.scrolled, want.scrolled));
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    attr_now       = ATTR_RESET;
    blank_screen();

    // Directed rows: reads after reset, range edges, printing, new lines,
    // the unused kind, codes next to the new-line codes and a clear.
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd31, 7'd127,
                                      5'd0, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd24, 7'd0,
                                      5'd0, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd0, 7'd80,
                                      5'd0, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd23, 7'd79,
                                      5'd0, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_PUT, 8'h41, 5'd0, 7'd0,
                                      5'd0, 7'd1, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_PUT, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd2, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_PUT, 8'hFF, 5'd0, 7'd0,
                                      5'd0, 7'd3, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd3, 8'h41, 8'hFF, 1'b0));
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd0, 7'd2,
                                      5'd0, 7'd3, 8'hFF, 8'hFF, 1'b0));
    directed_rows.push_back(typed_row(KIND_PUT, LINE_FEED, 5'd0, 7'd0,
                                      5'd1, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_PUT, CARRIAGE_RETURN, 5'd0, 7'd0,
                                      5'd2, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_SPARE, 8'hFF, 5'd31, 7'd127,
                                      5'd2, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(model_row(KIND_PUT, 8'h09, 5'd0, 7'd0));
    directed_rows.push_back(model_row(KIND_PUT, 8'h0B, 5'd0, 7'd0));
    directed_rows.push_back(model_row(KIND_PUT, 8'h0C, 5'd0, 7'd0));
    directed_rows.push_back(model_row(KIND_PUT, 8'h0E, 5'd0, 7'd0));
    directed_rows.push_back(model_row(KIND_READ, 8'h00, 5'd2, 7'd1));
    directed_rows.push_back(model_row(KIND_READ, 8'h00, 5'd2, 7'd3));
    directed_rows.push_back(typed_row(KIND_CLEAR, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd0, 8'h00, 8'h00, 1'b0));
    directed_rows.push_back(typed_row(KIND_READ, 8'h00, 5'd2, 7'd0,
                                      5'd0, 7'd0, 8'h00, 8'h00, 1'b0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The attribute is written while the post-reset clearing pass runs.
    write_attr(8'hFF);
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].item, 14, directed_rows[i].typed,
                directed_rows[i].result);
    end
    await_drain();

    // Sender idles rarely first, then often, then never.
    write_attr(8'h00);
    run_phase(PHASE_BEATS, 14);
    write_attr(BYTE_W'($urandom_range(1, 254)));
    run_phase(PHASE_BEATS, 80);
    write_attr(ATTR_RESET);
    run_phase(PHASE_BEATS, 0);

    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_store.sv
hdl/tcw_addr.sv
hdl/tcw_seq.sv
hdl/text_console_writer_core.sv
dv/tb.sv
